// ===== rtl/bitmap_range_engine_core_assert.svh =====
// Assertion macros for the bitmap range engine.
// Define ASSERT_OFF to compile the checks out.
`ifndef BITMAP_RANGE_ENGINE_CORE_ASSERT_SVH
`define BITMAP_RANGE_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap range engine check failed");

// next-cycle implication
`define BRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap range engine check failed");

`else

`define BRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bre_pkg;

  localparam int CAP_W  = 11;  // bit_capacity register
  localparam int IDX_W  = 10;  // range_start / range_end
  localparam int RES_W  = 11;  // search results, two's complement
  localparam int BASE_W = 12;  // running bit offset of the current word
  localparam int REL_W  = 13;  // signed offsets against the word base

  localparam logic [RES_W-1:0] NONE = {RES_W{1'b1}};  // -1

  // register index, paddr[2]
  localparam logic REG_BIT_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_FILL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_INVERT = 2'd3
  } op_e;

  typedef struct packed {
    logic clr;       // write one zero word of the post-reset sweep
    logic start;     // latch the item, reset search state
    logic step;      // read the next map word
    logic load_out;  // copy results to the output register
  } bre_cmd_t;

  typedef struct packed {
    logic clr_last;   // sweep is at the last word
    logic cap_zero;   // effective capacity is zero
    logic last_word;  // word being issued is the last one under the capacity
    logic pipe_busy;  // words still in flight
    logic out_free;   // output register can take a result this cycle
  } bre_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bre_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bre_dp #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bre_pkg::bre_cmd_t         cmd_i,
  output bre_pkg::bre_stat_t        stat_o,
  input  logic [bre_pkg::CAP_W-1:0] cap_cfg_i,
  input  logic [1:0]                op_i,
  input  logic [bre_pkg::IDX_W-1:0] range_start_i,
  input  logic [bre_pkg::IDX_W-1:0] range_end_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic                      bit_value_o,
  output logic                      range_error_o,
  output logic [bre_pkg::RES_W-1:0] first_free_o,
  output logic [bre_pkg::RES_W-1:0] last_free_o,
  output logic [bre_pkg::RES_W-1:0] first_busy_o,
  output logic [bre_pkg::RES_W-1:0] last_busy_o
);
  import bre_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int PW        = 1 << BW;

  localparam logic signed [REL_W-1:0] W_S   = REL_W'(WORD_BITS);
  localparam logic signed [REL_W-1:0] WM1_S = REL_W'(WORD_BITS - 1);

  // lowest set bit, halving the window each step
  function automatic logic [BW-1:0] find_low(input logic [PW-1:0] v_in);
    logic [PW-1:0] v;
    logic [BW-1:0] idx;
    v   = v_in;
    idx = '0;
    for (int k = BW - 1; k >= 0; k--) begin
      if ((v & ((PW'(1) << (1 << k)) - PW'(1))) == '0) begin
        idx = idx | BW'(1 << k);
        v   = v >> (1 << k);
      end
    end
    return idx;
  endfunction

  // highest set bit
  function automatic logic [BW-1:0] find_high(input logic [PW-1:0] v_in);
    logic [PW-1:0] v;
    logic [BW-1:0] idx;
    v   = v_in;
    idx = '0;
    for (int k = BW - 1; k >= 0; k--) begin
      if ((v >> (1 << k)) != '0) begin
        idx = idx | BW'(1 << k);
        v   = v >> (1 << k);
      end
    end
    return idx;
  endfunction

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  // item
  op_e                op_q;
  logic [IDX_W-1:0]   s_q, e_q;
  logic [CAP_W-1:0]   cap_q;
  logic               err_q;
  logic [CAP_W-1:0]   cap_eff;
  logic               err_d;

  // issue stage
  logic [AW-1:0]      addr_q;
  logic [BASE_W-1:0]  base_q;
  logic [AW-1:0]      clr_addr_q;

  // modify stage
  logic               vld_b_q;
  logic [AW-1:0]      addr_b_q;
  logic [BASE_W-1:0]  base_b_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic signed [REL_W-1:0] lo, hi, hi1;
  logic [WORD_BITS-1:0] ge_s, le_e, rng, new_word;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // search stage
  logic               vld_c_q;
  logic [BASE_W-1:0]  base_c_q;
  logic [WORD_BITS-1:0] word_c_q;
  logic signed [REL_W-1:0] rem;
  logic [WORD_BITS-1:0] vmask, zeros, ones;
  logic [BW-1:0]      lz, hz, lo1, hi1_idx;

  // running results
  logic               bit_q;
  logic               found_free_q, found_busy_q;
  logic [RES_W-1:0]   ff_q, lf_q, fb_q, lb_q;

  // output register
  logic               out_valid_q;
  logic               bit_out_q, err_out_q;
  logic [RES_W-1:0]   ff_out_q, lf_out_q, fb_out_q, lb_out_q;

  assign cap_eff = (32'(cap_cfg_i) > MAX_BITS) ? CAP_W'(MAX_BITS) : cap_cfg_i;

  always_comb begin
    if (op_e'(op_i) == OP_READ) begin
      err_d = (CAP_W'(range_start_i) >= cap_eff);
    end else begin
      err_d = (range_end_i < range_start_i) || (CAP_W'(range_end_i) >= cap_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_e'(op_i);
      s_q   <= range_start_i;
      e_q   <= range_end_i;
      cap_q <= cap_eff;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      base_q     <= '0;
      clr_addr_q <= '0;
      vld_b_q    <= 1'b0;
      vld_c_q    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        addr_q <= '0;
        base_q <= '0;
      end else if (cmd_i.step) begin
        addr_q <= addr_q + AW'(1);
        base_q <= base_q + BASE_W'(WORD_BITS);
      end
      if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      vld_b_q <= cmd_i.step;
      vld_c_q <= vld_b_q;
    end
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.step) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_b_q <= addr_q;
    base_b_q <= base_q;
    base_c_q <= base_b_q;
    word_c_q <= new_word;
  end

  // range mask for this word
  always_comb begin
    lo  = $signed({3'b000, s_q}) - $signed({1'b0, base_b_q});
    hi  = $signed({3'b000, e_q}) - $signed({1'b0, base_b_q});
    hi1 = hi + REL_W'(1);
    if (lo <= REL_W'(0)) begin
      ge_s = '1;
    end else if (lo >= W_S) begin
      ge_s = '0;
    end else begin
      ge_s = {WORD_BITS{1'b1}} << lo[BW-1:0];
    end
    if (hi < REL_W'(0)) begin
      le_e = '0;
    end else if (hi >= WM1_S) begin
      le_e = '1;
    end else begin
      le_e = ~({WORD_BITS{1'b1}} << hi1[BW-1:0]);
    end
    rng = ge_s & le_e;
    // a rejected range leaves the word as read
    if (err_q) begin
      new_word = rd_data_q;
    end else begin
      case (op_q)
        OP_FILL:   new_word = rd_data_q | rng;
        OP_CLEAR:  new_word = rd_data_q & ~rng;
        OP_INVERT: new_word = rd_data_q ^ rng;
        default:   new_word = rd_data_q;
      endcase
    end
  end

  always_comb begin
    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = vld_b_q && !err_q && (op_q != OP_READ);
      wr_addr = addr_b_q;
      wr_data = new_word;
    end
  end

  // search over the bits of this word below the capacity
  always_comb begin
    rem = $signed({2'b00, cap_q}) - $signed({1'b0, base_c_q});
    if (rem >= W_S) begin
      vmask = '1;
    end else begin
      vmask = ~({WORD_BITS{1'b1}} << rem[BW-1:0]);
    end
    zeros   = ~word_c_q & vmask;
    ones    = word_c_q & vmask;
    lz      = find_low(PW'(zeros));
    hz      = find_high(PW'(zeros));
    lo1     = find_low(PW'(ones));
    hi1_idx = find_high(PW'(ones));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q        <= 1'b0;
      found_free_q <= 1'b0;
      found_busy_q <= 1'b0;
      ff_q         <= NONE;
      lf_q         <= NONE;
      fb_q         <= NONE;
      lb_q         <= NONE;
    end else if (cmd_i.start) begin
      bit_q        <= 1'b0;
      found_free_q <= 1'b0;
      found_busy_q <= 1'b0;
      ff_q         <= NONE;
      lf_q         <= NONE;
      fb_q         <= NONE;
      lb_q         <= NONE;
    end else begin
      if (vld_b_q && (op_q == OP_READ) && !err_q && (lo >= REL_W'(0)) && (lo < W_S)) begin
        bit_q <= rd_data_q[lo[BW-1:0]];
      end
      if (vld_c_q) begin
        if (zeros != '0) begin
          if (!found_free_q) begin
            ff_q <= RES_W'(base_c_q + BASE_W'(lz));
          end
          found_free_q <= 1'b1;
          lf_q         <= RES_W'(base_c_q + BASE_W'(hz));
        end
        if (ones != '0) begin
          if (!found_busy_q) begin
            fb_q <= RES_W'(base_c_q + BASE_W'(lo1));
          end
          found_busy_q <= 1'b1;
          lb_q         <= RES_W'(base_c_q + BASE_W'(hi1_idx));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      bit_out_q <= bit_q;
      err_out_q <= err_q;
      ff_out_q  <= ff_q;
      lf_out_q  <= lf_q;
      fb_out_q  <= fb_q;
      lb_out_q  <= lb_q;
    end
  end

  assign stat_o.clr_last  = (clr_addr_q == AW'(NUM_WORDS - 1));
  assign stat_o.cap_zero  = (cap_eff == '0);
  assign stat_o.last_word = ({1'b0, base_q} + REL_W'(WORD_BITS)) >= REL_W'(cap_q);
  assign stat_o.pipe_busy = vld_b_q || vld_c_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign bit_value_o   = bit_out_q;
  assign range_error_o = err_out_q;
  assign first_free_o  = ff_out_q;
  assign last_free_o   = lf_out_q;
  assign first_busy_o  = fb_out_q;
  assign last_busy_o   = lb_out_q;

endmodule

`default_nettype wire

// ===== rtl/bre_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bre_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bre_pkg::bre_stat_t stat_i,
  output bre_pkg::bre_cmd_t  cmd_o
);
  import bre_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.cap_zero ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.last_word) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      stall_q <= 1'b1;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

// ===== rtl/bitmap_range_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_range_engine_core_assert.svh"

// Bit map of up to MAX_BITS bits held in a single-port-write, single-port-read
// memory of WORD_BITS-bit words. After reset the map is swept to zero, one word
// per cycle, with in_stall_o high. Each beat reads one bit or fills, clears or
// inverts an inclusive range, then returns the lowest and highest zero and one
// bit below bit_capacity (-1 if none). An item makes one pass through the words
// under the capacity (none when the capacity is zero), one word read per cycle,
// with modify and search in two stages behind the read. A result sits in an
// output register, so the next beat is taken while it waits; the result after
// that holds the engine for as long as the output stays stalled.
// bit_capacity (address 0) is to be written only while the block is idle;
// the user is bound by this, and the block itself does not enforce it.
module bitmap_range_engine_core #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [bre_pkg::IDX_W-1:0]        range_start_i,
  input  logic [bre_pkg::IDX_W-1:0]        range_end_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             bit_value_o,
  output logic                             range_error_o,
  output logic signed [bre_pkg::RES_W-1:0] first_free_o,
  output logic signed [bre_pkg::RES_W-1:0] last_free_o,
  output logic signed [bre_pkg::RES_W-1:0] first_busy_o,
  output logic signed [bre_pkg::RES_W-1:0] last_busy_o
);
  import bre_pkg::*;

  logic [CAP_W-1:0] cap_q;
  bre_cmd_t         cmd;
  bre_stat_t        stat;
  logic [RES_W-1:0] ff, lf, fb, lb;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(1024);
    end else if (psel && penable && pwrite && (paddr[2] == REG_BIT_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BIT_CAPACITY) ? 32'(cap_q) : '0;

  bre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bre_dp #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cap_cfg_i     (cap_q),
    .op_i          (op_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .bit_value_o   (bit_value_o),
    .range_error_o (range_error_o),
    .first_free_o  (ff),
    .last_free_o   (lf),
    .first_busy_o  (fb),
    .last_busy_o   (lb)
  );

  assign first_free_o = ff;
  assign last_free_o  = lf;
  assign first_busy_o = fb;
  assign last_busy_o  = lb;

  `BRE_ASSERT_IMP(a_clr_stalls, clk_i, rst_ni, cmd.clr, in_stall_o)
  `BRE_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `BRE_ASSERT_IMP(a_free_pair, clk_i, rst_ni, out_valid_o, (ff == NONE) == (lf == NONE))
  `BRE_ASSERT_IMP(a_busy_pair, clk_i, rst_ni, out_valid_o, (fb == NONE) == (lb == NONE))

endmodule

`default_nettype wire
